@@ hdl/min_max_scale_to_range_core_defines.svh @@
// assertion macros for the min-max scaling core
// used by the top level; expects clk and arst_n in scope
`ifndef MIN_MAX_SCALE_TO_RANGE_CORE_DEFINES_SVH
`define MIN_MAX_SCALE_TO_RANGE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define MMSR_CHECK(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("mmsr check failed");
`define MMSR_CHECK_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mmsr implication failed");
`else
`define MMSR_CHECK(label, expr)
`define MMSR_CHECK_IMP(label, ante, cons)
`endif

`endif

@@ hdl/mmsr_pkg.sv @@
// shared types, constants and helper functions for the min-max scaling core
// no dependencies
`default_nettype none

package mmsr_pkg;

	localparam int DIV_STAGES = 8;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	localparam logic REG_TARGET_START = 1'b0;
	localparam logic REG_TARGET_END   = 1'b1;

	typedef struct packed {
		logic neg;
		logic zero_rng;
		logic last;
	} side_t;

	typedef struct packed {
		logic [15:0] rem;
		logic [15:0] lo;
		logic [15:0] quo;
	} div_work_t;

	// one restoring division step, one quotient bit
	function automatic div_work_t div_step(input div_work_t w, input logic [15:0] den);
		logic [16:0] t;
		div_work_t   r;
		t    = {w.rem, w.lo[15]};
		r.lo = {w.lo[14:0], 1'b0};
		if (t >= {1'b0, den}) begin
			r.rem = 16'(t - {1'b0, den});
			r.quo = {w.quo[14:0], 1'b1};
		end else begin
			r.rem = t[15:0];
			r.quo = {w.quo[14:0], 1'b0};
		end
		return r;
	endfunction

	// integer part of a q8.8 value, truncated toward zero
	function automatic logic [7:0] trunc_int(input logic [15:0] v);
		logic up;
		up = v[15] && (v[7:0] != 8'd0);
		return v[15:8] + {7'd0, up};
	endfunction

endpackage

`default_nettype wire

@@ hdl/min_max_scale_to_range_core.sv @@
// min-max scaling core: loads a set of q8.8 samples, then emits them rescaled
// uses mmsr_pkg, mmsr_store, mmsr_div and min_max_scale_to_range_core_defines.svh
//
//   channel   dir  payload                                        handshake
//   s_axis    in   tdata[15:0] sample, tlast is_last               tvalid/tready
//   m_axis    out  tdata scaled/set_min/set_max/overflowed, tlast   tvalid/tready
//   cfg       in   cfg_addr register index, cfg_wdata value         cfg_we
//
// loading takes one sample per cycle; the emit pass starts after the last sample
// and reads the store once per cycle while the output is not stalled, through a
// multiply stage and an 8-stage divider.
// no sample is taken while a set is being emitted; output stalls freeze the emit pipe.
// reset clears the set state and loads the default range registers.
`default_nettype none
`include "min_max_scale_to_range_core_defines.svh"

module min_max_scale_to_range_core #(
	parameter int MAX_SAMPLES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [15:0] scaled, [23:16] set_min,
	                                         // [31:24] set_max, [32] overflowed
	output logic             m_axis_tlast,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_addr,
	input  wire logic [15:0] cfg_wdata
);

	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);

	mmsr_pkg::state_t state_q, state_d;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      issue_q;
	logic signed [15:0] min_q, max_q;
	logic               drop_q;
	logic [15:0]        start_q, end_q;

	logic               in_xfer, out_xfer, has_room, done, adv, issue_go;
	logic [15:0]        rdata;

	logic               rd_vld_s1, rd_last_s1;
	logic               vld_s2;
	logic [31:0]        prod_s2;
	mmsr_pkg::side_t    side_s2;

	logic               div_vld;
	logic [15:0]        div_quo;
	mmsr_pkg::side_t    div_side;

	logic [15:0]        scaled_q;
	logic               out_vld_q, out_last_q;

	logic signed [16:0] span;
	logic [15:0]        span_mag;
	logic [16:0]        diff;
	logic [15:0]        range;
	logic signed [17:0] q18, r18;
	logic [15:0]        fin;

	// state machine
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mmsr_pkg::ST_LOAD: if (in_xfer && s_axis_tlast) state_d = mmsr_pkg::ST_EMIT;
			mmsr_pkg::ST_EMIT: if (done) state_d = mmsr_pkg::ST_LOAD;
			default:           state_d = mmsr_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		unique case (state_q)
			mmsr_pkg::ST_LOAD: s_axis_tready = 1'b1;
			mmsr_pkg::ST_EMIT: s_axis_tready = 1'b0;
			default:           s_axis_tready = 1'b0;
		endcase
	end

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = out_vld_q && m_axis_tready;
	assign done     = out_xfer && out_last_q;
	assign has_room = count_q != CW'(MAX_SAMPLES);
	assign adv      = !out_vld_q || m_axis_tready;
	assign issue_go = (state_q == mmsr_pkg::ST_EMIT) && (issue_q != count_q) && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmsr_pkg::ST_LOAD;
			count_q <= '0;
			issue_q <= '0;
			min_q   <= '0;
			max_q   <= '0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done) begin
				count_q <= '0;
				issue_q <= '0;
				min_q   <= '0;
				max_q   <= '0;
				drop_q  <= 1'b0;
			end else begin
				if (issue_go) begin
					issue_q <= issue_q + CW'(1);
				end
				if (in_xfer && has_room) begin
					count_q <= count_q + CW'(1);
					if (count_q == '0) begin
						min_q <= s_axis_tdata;
						max_q <= s_axis_tdata;
					end else begin
						if ($signed(s_axis_tdata) < min_q) min_q <= s_axis_tdata;
						if ($signed(s_axis_tdata) > max_q) max_q <= s_axis_tdata;
					end
				end
				if (in_xfer && !has_room) begin
					drop_q <= 1'b1;
				end
			end
		end
	end

	// range registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 16'hFF00;
			end_q   <= 16'h0100;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				mmsr_pkg::REG_TARGET_START: start_q <= cfg_wdata;
				mmsr_pkg::REG_TARGET_END:   end_q   <= cfg_wdata;
				default:                    ;
			endcase
		end
	end

	mmsr_store #(
		.DEPTH (MAX_SAMPLES),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (in_xfer && has_room),
		.waddr (count_q[AW-1:0]),
		.wdata (s_axis_tdata),
		.re    (issue_go),
		.raddr (issue_q[AW-1:0]),
		.rdata (rdata)
	);

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else if (adv) begin
			rd_vld_s1 <= issue_go;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_last_s1 <= (issue_q + CW'(1)) == count_q;
		end
	end

	// multiply stage, magnitudes only
	always_comb begin
		span     = $signed({end_q[15], end_q}) - $signed({start_q[15], start_q});
		span_mag = span[16] ? 16'(-span) : span[15:0];
		diff     = {rdata[15], rdata} - {min_q[15], min_q};
		range    = 16'(max_q - min_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= rd_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2          <= span_mag * diff[15:0];
			side_s2.neg      <= span[16];
			side_s2.zero_rng <= max_q == min_q;
			side_s2.last     <= rd_last_s1;
		end
	end

	mmsr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s2),
		.num       (prod_s2),
		.den       (range),
		.side_in   (side_s2),
		.out_valid (div_vld),
		.quo       (div_quo),
		.side_out  (div_side)
	);

	// sign, offset and saturation
	always_comb begin
		q18 = div_side.neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
		r18 = q18 + $signed({{2{start_q[15]}}, start_q});
		if (div_side.zero_rng) begin
			fin = start_q;
		end else if (r18 > 18'sd32767) begin
			fin = 16'h7FFF;
		end else if (r18 < -18'sd32768) begin
			fin = 16'h8000;
		end else begin
			fin = r18[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			scaled_q   <= fin;
			out_last_q <= div_side.last;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {7'd0, drop_q, mmsr_pkg::trunc_int(max_q),
	                        mmsr_pkg::trunc_int(min_q), scaled_q};

	`MMSR_CHECK(chk_no_overlap, !(s_axis_tready && m_axis_tvalid))
	`MMSR_CHECK(chk_count_bound, count_q <= CW'(MAX_SAMPLES))
	`MMSR_CHECK_IMP(chk_final_after_issue, m_axis_tvalid && m_axis_tlast, issue_q == count_q)
	`MMSR_CHECK_IMP(chk_min_le_max, count_q != '0, min_q <= max_q)

endmodule

`default_nettype wire

@@ hdl/mmsr_store.sv @@
// sample store: single write port, single read port, registered read data
// no package dependencies
`default_nettype none

module mmsr_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [15:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic [15:0]        rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/mmsr_div.sv @@
// pipelined unsigned divider, 32 by 16 bits, two quotient bits per stage
// uses mmsr_pkg; caller guarantees quotient fits 16 bits and holds den for a run
`default_nettype none

module mmsr_div (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire logic [31:0]     num,
	input  wire logic [15:0]     den,
	input  wire mmsr_pkg::side_t side_in,
	output logic                 out_valid,
	output logic [15:0]          quo,
	output mmsr_pkg::side_t      side_out
);

	localparam int N = mmsr_pkg::DIV_STAGES;

	mmsr_pkg::div_work_t work_q [N];
	mmsr_pkg::side_t     side_q [N];
	logic [N-1:0]        vld_q;
	mmsr_pkg::div_work_t init_w;

	assign init_w = '{rem: num[31:16], lo: num[15:0], quo: 16'd0};

	for (genvar k = 0; k < N; k++) begin : g_stage
		mmsr_pkg::div_work_t w_in;
		mmsr_pkg::div_work_t w_mid;
		mmsr_pkg::div_work_t w_out;
		mmsr_pkg::side_t     s_in;
		logic                v_in;

		if (k == 0) begin : g_first
			assign w_in = init_w;
			assign s_in = side_in;
			assign v_in = in_valid;
		end else begin : g_rest
			assign w_in = work_q[k-1];
			assign s_in = side_q[k-1];
			assign v_in = vld_q[k-1];
		end

		always_comb begin
			w_mid = mmsr_pkg::div_step(w_in, den);
			w_out = mmsr_pkg::div_step(w_mid, den);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				work_q[k] <= w_out;
				side_q[k] <= s_in;
			end
		end
	end

	assign out_valid = vld_q[N-1];
	assign quo       = work_q[N-1].quo;
	assign side_out  = side_q[N-1];

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking bench for min_max_scale_to_range_core: sample sets over the input stream,
// rescaled results checked against a predictor held in a small scoreboard class
// depends on mmsr_pkg and the core rtl

module tb_top;

	localparam int CAPACITY       = 64;
	localparam int SETTLE_CYCLES  = 24;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_ITEMS   = 250;

	typedef struct packed {
		logic [15:0] scaled;
		logic [7:0]  lo_int;
		logic [7:0]  hi_int;
		logic        dropped;
		logic        closing;
	} scaled_result_t;

	class scale_board;
		logic signed [15:0] store[];
		int                 cap;
		int                 fill;
		logic signed [15:0] lo, hi;
		bit                 dropped;
		logic signed [15:0] t_start, t_end;
		scaled_result_t     pending_q[$];
		int                 fails, checked, sets, drop_sets, reg_writes;

		function new(int cap_i);
			cap = cap_i;
			store = new[cap_i];
			fill = 0;
			lo = '0;
			hi = '0;
			dropped = 0;
			t_start = -16'sd256;
			t_end = 16'sd256;
		endfunction

		function void set_reg(logic addr, logic [15:0] val);
			reg_writes++;
			if (addr == mmsr_pkg::REG_TARGET_START)
				t_start = val;
			else if (addr == mmsr_pkg::REG_TARGET_END)
				t_end = val;
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		function logic [15:0] rescale(logic signed [15:0] x);
			longint span, num, q, r;
			span = longint'(hi) - longint'(lo);
			if (span <= 0)
				return t_start;
			num = (longint'(t_end) - longint'(t_start)) * (longint'(x) - longint'(lo));
			q = num / span;
			r = q + longint'(t_start);
			if (r > 32767)
				r = 32767;
			if (r < -32768)
				r = -32768;
			return 16'(r);
		endfunction

		task report(string what);
			fails++;
			if (fails <= 40)
				$display("mismatch at %0t: %s", $realtime, what);
		endtask

		// accepted input transfer
		function void note_sample(logic signed [15:0] x, logic last);
			scaled_result_t r;
			if (fill < cap) begin
				if (fill == 0) begin
					lo = x;
					hi = x;
				end else begin
					if (x < lo)
						lo = x;
					if (x > hi)
						hi = x;
				end
				store[fill] = x;
				fill++;
			end else begin
				dropped = 1;
			end
			if (!last)
				return;
			sets++;
			if (dropped)
				drop_sets++;
			for (int k = 0; k < fill; k++) begin
				r.scaled = rescale(store[k]);
				r.lo_int = 8'(int'(lo) / 256);
				r.hi_int = 8'(int'(hi) / 256);
				r.dropped = dropped;
				r.closing = (k + 1 == fill);
				pending_q.push_back(r);
			end
			fill = 0;
			lo = '0;
			hi = '0;
			dropped = 0;
		endfunction

		// accepted output transfer
		task check_result(logic [39:0] d, logic fin);
			scaled_result_t w;
			if (pending_q.size() == 0) begin
				report($sformatf("result %h with nothing pending", d));
				return;
			end
			w = pending_q.pop_front();
			checked++;
			if (d[15:0] !== w.scaled)
				report($sformatf("scaled %h, want %h", d[15:0], w.scaled));
			if (d[23:16] !== w.lo_int)
				report($sformatf("set_min %h, want %h", d[23:16], w.lo_int));
			if (d[31:24] !== w.hi_int)
				report($sformatf("set_max %h, want %h", d[31:24], w.hi_int));
			if (d[32] !== w.dropped)
				report($sformatf("overflowed %b, want %b", d[32], w.dropped));
			if (fin !== w.closing)
				report($sformatf("tlast %b, want %b", fin, w.closing));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;     // [15:0] sample
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;          // [15:0] scaled, [23:16] set_min, [31:24] set_max,
	                                    // [32] overflowed
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_addr = '0;
	logic [15:0] cfg_wdata = '0;

	bit          src_idle = 1'b1;
	bit          snk_idle = 1'b1;
	int          items_sent = 0;
	int          idle_run = 0;
	scale_board  sb;

	min_max_scale_to_range_core #(
		.MAX_SAMPLES(CAPACITY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_sample(input logic [15:0] x, input logic last);
		int gap;
		gap = src_idle ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = x;
		s_axis_tlast = last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_sample(x, last);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_set(input logic [15:0] vals[$]);
		foreach (vals[i])
			send_sample(vals[i], i == vals.size() - 1);
	endtask

	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic addr, input logic [15:0] val);
		cfg_we = 1'b1;
		cfg_addr = addr;
		cfg_wdata = val;
		sb.set_reg(addr, val);
		@(negedge clk);
		cfg_we = 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_value(logic [15:0] base);
		logic [15:0] corner[4];
		corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
		case ($urandom_range(0, 7))
			0: return corner[$urandom_range(0, 3)];
			1, 2: return base + 16'($urandom_range(0, 30)) - 16'd15;
			3: return base;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_reg_value();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_set(input int len);
		logic [15:0] base;
		base = 16'($urandom);
		for (int i = 0; i < len; i++)
			send_sample(pick_value(base), i == len - 1);
	endtask

	// result side
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = snk_idle ? $urandom_range(0, 10) : 0;
			if (gap > 0) begin
				m_axis_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_result(m_axis_tdata, m_axis_tlast);
		end
	end

	// no transfer on either side for too long
	initial begin
		while (idle_run < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int len, start_items;
		sb = new(CAPACITY);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed sets, default range first
		send_set('{16'h8000, 16'h7FFF, 16'h0000, 16'h0100});
		send_set('{16'h0A80, 16'h0A80, 16'h0A80});
		send_set('{16'hFFFF});
		send_set('{16'hFE7F, 16'h0181});
		drain();
		write_reg(mmsr_pkg::REG_TARGET_START, 16'h8000);
		write_reg(mmsr_pkg::REG_TARGET_END, 16'h7FFF);
		send_set('{16'h8000, 16'h7FFF, 16'h1234, 16'hC000});
		drain();
		write_reg(mmsr_pkg::REG_TARGET_START, 16'h7FFF);
		write_reg(mmsr_pkg::REG_TARGET_END, 16'h8000);
		send_set('{16'h0001, 16'hFFFF, 16'h0000});
		drain();
		write_reg(mmsr_pkg::REG_TARGET_START, 16'h0100);
		write_reg(mmsr_pkg::REG_TARGET_END, 16'h0100);
		send_set('{16'h0003, 16'h0042});
		drain();
		write_reg(mmsr_pkg::REG_TARGET_START, 16'hFF00);
		write_reg(mmsr_pkg::REG_TARGET_END, 16'h0100);

		// random sets; the first one overruns the store and ends on a dropped sample
		start_items = items_sent;
		len = CAPACITY + 2;
		while (items_sent - start_items < RANDOM_ITEMS) begin
			src_idle = ($urandom_range(0, 3) != 0);
			snk_idle = ($urandom_range(0, 3) != 0);
			random_set(len);
			if ($urandom_range(0, 3) == 0) begin
				drain();
				if ($urandom_range(0, 2) != 0)
					write_reg(mmsr_pkg::REG_TARGET_START, pick_reg_value());
				if ($urandom_range(0, 2) != 0)
					write_reg(mmsr_pkg::REG_TARGET_END, pick_reg_value());
			end
			case ($urandom_range(0, 19))
				0: len = $urandom_range(CAPACITY + 1, CAPACITY + 4);
				1, 2, 3: len = $urandom_range(11, CAPACITY);
				default: len = $urandom_range(1, 10);
			endcase
		end
		drain();

		$display("sent %0d samples in %0d sets (%0d with dropped samples), %0d register writes",
			items_sent, sb.sets, sb.drop_sets, sb.reg_writes);
		$display("checked %0d scaled results, %0d mismatches", sb.checked, sb.fails);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
